// File: hw/rtl/nhht_pkg.sv
package nhht_pkg;

	// Field widths of the stream payload.
	localparam int CMD_W    = 2;
	localparam int KEY_W    = 8;
	localparam int HOP_W    = 8;
	localparam int STATUS_W = 3;

	// One stored way: valid flag, next hop and key, key in the lowest bits.
	localparam int ENT_W = 1 + HOP_W + KEY_W;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] STAT_UPDATED  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_HIT      = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_MISS     = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd5;

endpackage

// File: hw/rtl/nhht_ram.sv
module nhht_ram #(
	parameter int WIDTH = 68,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                              wr_data,
	input  logic                                          rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                              rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/next_hop_hash_table_top.sv
// Channel   Direction  tdata                               tuser
// s_axis    in         dest_node [7:0], next_hop [15:8]    cmd [1:0]
// m_axis    out        hop_out [7:0]                       status [2:0]
//
// Each transaction first reads the bucket row from the RAM, then compares the ways,
// writes the row back and loads the result register.
// One command is in flight at a time; a new one is taken as soon as the previous
// result sits in the output register, even if the sink has not yet taken it.
// A stalled sink holds the command in its compare cycle until the result register frees.
// Reset clears a per-bucket valid flag, so the table is empty at once with no sweep;
// a clear command does the same in its compare cycle.
module next_hop_hash_table_top #(
	parameter int SLOTS = 16,
	parameter int WAYS  = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [15:0]                     s_axis_tdata,  // dest_node [7:0], next_hop [15:8]
	input  logic [nhht_pkg::CMD_W-1:0]      s_axis_tuser,  // cmd [1:0]
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [nhht_pkg::HOP_W-1:0]      m_axis_tdata,  // hop_out [7:0]
	output logic [nhht_pkg::STATUS_W-1:0]   m_axis_tuser   // status [2:0]
);

	import nhht_pkg::*;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ROW_W  = WAYS * ENT_W;
	localparam int KEYS   = 1 << KEY_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LOOK = 1'b1;

	logic                state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_W-1:0]    dest_q;
	logic [HOP_W-1:0]    hop_q;
	logic [SLOT_W-1:0]   bucket_q;
	logic [SLOTS-1:0]    row_valid_q;
	logic                m_tvalid_q;
	logic [STATUS_W-1:0] status_q;
	logic [HOP_W-1:0]    hop_out_q;

	logic                accept;
	logic                out_free;
	logic                done;
	logic [KEY_W-1:0]    in_dest;
	logic [HOP_W-1:0]    in_hop;
	logic [SLOT_W-1:0]   bucket_lut [KEYS];
	logic [SLOT_W-1:0]   in_bucket;

	logic [ROW_W-1:0]    rd_row;
	logic [ROW_W-1:0]    wr_row;
	logic                wr_en;

	logic [WAYS-1:0]     way_valid;
	logic [KEY_W-1:0]    way_key [WAYS];
	logic [HOP_W-1:0]    way_hop [WAYS];
	logic                match_any;
	logic                free_any;
	logic [WAYS-1:0]     match_sel;
	logic [WAYS-1:0]     free_sel;
	logic [HOP_W-1:0]    match_hop;
	logic [STATUS_W-1:0] res_status;
	logic [HOP_W-1:0]    res_hop;

	assign in_dest = s_axis_tdata[KEY_W-1:0];
	assign in_hop  = s_axis_tdata[KEY_W +: HOP_W];

	// Handshakes: one command at a time, result register acts as the skid.
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_tvalid_q || m_axis_tready;
	assign done          = (state_q == ST_LOOK) && out_free;

	// Bucket is the key modulo the slot count, looked up in a constant table.
	for (genvar k = 0; k < KEYS; k++) begin : g_bucket_lut
		assign bucket_lut[k] = SLOT_W'(k % SLOTS);
	end

	assign in_bucket = bucket_lut[in_dest];

	// Bucket rows: all ways of one bucket in a single word.
	nhht_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SLOTS)
	) u_rows (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (bucket_q),
		.wr_data (wr_row),
		.rd_en   (accept),
		.rd_addr (in_bucket),
		.rd_data (rd_row)
	);

	// Unpack the row; a bucket not written since the last clear reads as empty.
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			way_key[w]   = rd_row[w*ENT_W +: KEY_W];
			way_hop[w]   = rd_row[w*ENT_W + KEY_W +: HOP_W];
			way_valid[w] = rd_row[w*ENT_W + KEY_W + HOP_W] && row_valid_q[bucket_q];
		end
	end

	// Lowest matching way and lowest free way.
	always_comb begin
		match_any = 1'b0;
		free_any  = 1'b0;
		match_sel = '0;
		free_sel  = '0;
		match_hop = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!match_any && way_valid[w] && (way_key[w] == dest_q)) begin
				match_any    = 1'b1;
				match_sel[w] = 1'b1;
				match_hop    = way_hop[w];
			end
			if (!free_any && !way_valid[w]) begin
				free_any    = 1'b1;
				free_sel[w] = 1'b1;
			end
		end
	end

	// Row written back by a set: update the matching way, else fill the free way.
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			if (match_any) begin
				wr_row[w*ENT_W +: ENT_W] = {way_valid[w],
					match_sel[w] ? hop_q : way_hop[w], way_key[w]};
			end else if (free_sel[w]) begin
				wr_row[w*ENT_W +: ENT_W] = {1'b1, hop_q, dest_q};
			end else begin
				wr_row[w*ENT_W +: ENT_W] = {way_valid[w], way_hop[w], way_key[w]};
			end
		end
	end

	assign wr_en = done && (cmd_q == CMD_SET) && (match_any || free_any);

	// Result of the command.
	always_comb begin
		res_status = STAT_MISS;
		res_hop    = '0;
		unique case (cmd_q)
			CMD_SET: begin
				if (match_any) begin
					res_status = STAT_UPDATED;
				end else if (free_any) begin
					res_status = STAT_INSERTED;
				end else begin
					res_status = STAT_FULL;
				end
			end
			CMD_LOOKUP: begin
				if (match_any) begin
					res_status = STAT_HIT;
					res_hop    = match_hop;
				end
			end
			CMD_CLEAR: begin
				res_status = STAT_CLEARED;
			end
			default: begin
				res_status = STAT_MISS;
			end
		endcase
	end

	// Command registers, captured with the transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= s_axis_tuser;
			dest_q   <= in_dest;
			hop_q    <= in_hop;
			bucket_q <= in_bucket;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (done) begin
			status_q  <= res_status;
			hop_out_q <= res_hop;
		end
	end

	// Sequencer, result valid and per-bucket valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_tvalid_q  <= 1'b0;
			row_valid_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (done && (cmd_q == CMD_CLEAR)) begin
				row_valid_q <= '0;
			end else if (wr_en) begin
				row_valid_q[bucket_q] <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = hop_out_q;
	assign m_axis_tuser  = status_q;

endmodule
